/* rtl/http_request_byte_parser_defines.svh */
// Assertion macros for the HTTP request byte parser.
`ifndef HTTP_REQUEST_BYTE_PARSER_DEFINES_SVH
`define HTTP_REQUEST_BYTE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
`define HRBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrbp: implication check failed");
`define HRBP_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("hrbp: forbidden condition seen");
`else
`define HRBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define HRBP_ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

/* rtl/hrbp_pkg.sv */
// Shared types, codes and character tables of the HTTP request byte parser.
package hrbp_pkg;

    localparam logic [1:0] STATUS_PENDING  = 2'd0;
    localparam logic [1:0] STATUS_COMPLETE = 2'd1;
    localparam logic [1:0] STATUS_ERROR    = 2'd2;

    localparam logic [2:0] ROLE_DELIM   = 3'd0;
    localparam logic [2:0] ROLE_METHOD  = 3'd1;
    localparam logic [2:0] ROLE_URI     = 3'd2;
    localparam logic [2:0] ROLE_VERSION = 3'd3;
    localparam logic [2:0] ROLE_NAME    = 3'd4;
    localparam logic [2:0] ROLE_VALUE   = 3'd5;
    localparam logic [2:0] ROLE_BODY    = 3'd6;

    localparam logic [1:0] CFG_REQUEST_LINE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_HEADER_LINE_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_BODY_LIMIT         = 2'd2;
    localparam logic [1:0] CFG_HEADER_COUNT_LIMIT = 2'd3;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_C     = 8'h63;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        consumed;
        logic [7:0]  out_byte;
        logic [2:0]  byte_role;
        logic [31:0] content_length;
        logic        chunked;
    } rsp_t;

    // Classified byte handed from the front to the back.
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic [7:0] lc_byte;
        logic       tok;
        logic       dig;
        logic       ctl;
        logic       blank;
        logic       hex_ok;
        logic [3:0] hex_val;
    } cls_t;

    typedef struct packed {
        logic [15:0] request_line_limit;
        logic [15:0] header_line_limit;
        logic [31:0] body_limit;
        logic [7:0]  header_count_limit;
    } limits_t;

    function automatic logic [7:0] cl_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0:    c = "c";
            5'd1:    c = "o";
            5'd2:    c = "n";
            5'd3:    c = "t";
            5'd4:    c = "e";
            5'd5:    c = "n";
            5'd6:    c = "t";
            5'd7:    c = "-";
            5'd8:    c = "l";
            5'd9:    c = "e";
            5'd10:   c = "n";
            5'd11:   c = "g";
            5'd12:   c = "t";
            5'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] te_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0:    c = "t";
            5'd1:    c = "r";
            5'd2:    c = "a";
            5'd3:    c = "n";
            5'd4:    c = "s";
            5'd5:    c = "f";
            5'd6:    c = "e";
            5'd7:    c = "r";
            5'd8:    c = "-";
            5'd9:    c = "e";
            5'd10:   c = "n";
            5'd11:   c = "c";
            5'd12:   c = "o";
            5'd13:   c = "d";
            5'd14:   c = "i";
            5'd15:   c = "n";
            5'd16:   c = "g";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ck_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = "c";
            3'd1:    c = "h";
            3'd2:    c = "u";
            3'd3:    c = "n";
            3'd4:    c = "k";
            3'd5:    c = "e";
            3'd6:    c = "d";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] http_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = "H";
            3'd1:    c = "T";
            3'd2:    c = "T";
            3'd3:    c = "P";
            3'd4:    c = "/";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

/* rtl/http_request_byte_parser.sv */
// Top level of the HTTP/1.1 request byte parser: limits, front, queue, back.
//
// Usage: feed the request stream one word per cycle on req_valid/req_ready.
// Each word carries cmd (1 restarts the parser for a new request, 0 carries
// data_byte). Every accepted word yields exactly one result word on
// rsp_valid/rsp_ready with status, consumed flag, the byte (lowercased in
// header names), its role, the parsed Content-Length and the chunked flag.
// A result passes through the queue entry and then the output register of
// the parse engine; the classifying front is combinational. Throughput:
// one word per cycle while rsp_ready stays high, as the parse state
// updates on every popped word. When the receiver stalls, the output
// register holds its word and the two-entry queue absorbs up to two more
// words; req_ready drops only when that queue is full. Limits are written
// on cfg_write/cfg_index/cfg_data; the user must write them only while the
// block is idle, which the block does not enforce. They keep their values
// across restarts. Reset clears the queue, the output valid flag and all
// parse state, and loads the default limits; no clearing pass is needed.
module http_request_byte_parser #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  hrbp_pkg::req_t req_word,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output hrbp_pkg::rsp_t rsp_word,
    input  logic           cfg_write,
    input  logic [1:0]     cfg_index,
    input  logic [31:0]    cfg_data
);

`include "http_request_byte_parser_defines.svh"

    hrbp_pkg::limits_t limits_reg;
    hrbp_pkg::cls_t    cls_word;
    hrbp_pkg::cls_t    q_word;
    logic              q_full;
    logic              q_nonempty;
    logic              q_pop;

    // Limit registers; a write lands at the next edge.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.request_line_limit <= 16'd8192;
            limits_reg.header_line_limit  <= 16'd8192;
            limits_reg.body_limit         <= 32'd1048576;
            limits_reg.header_count_limit <= 8'd100;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hrbp_pkg::CFG_REQUEST_LINE_LIMIT:
                    limits_reg.request_line_limit <= cfg_data[15:0];
                hrbp_pkg::CFG_HEADER_LINE_LIMIT:
                    limits_reg.header_line_limit <= cfg_data[15:0];
                hrbp_pkg::CFG_BODY_LIMIT:
                    limits_reg.body_limit <= cfg_data;
                hrbp_pkg::CFG_HEADER_COUNT_LIMIT:
                    limits_reg.header_count_limit <= cfg_data[7:0];
                default:
                    limits_reg <= limits_reg;
            endcase
        end
    end

    // Accept a word whenever the queue has room.
    assign req_ready = !q_full;

    hrbp_front u_front (
        .req_word (req_word),
        .cls_word (cls_word)
    );

    hrbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_valid),
        .push_word (cls_word),
        .full      (q_full),
        .pop       (q_pop),
        .nonempty  (q_nonempty),
        .pop_word  (q_word)
    );

    hrbp_back #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .limits     (limits_reg),
        .q_nonempty (q_nonempty),
        .q_word     (q_word),
        .q_pop      (q_pop),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp_word   (rsp_word)
    );

    // Error words always carry the delimiter role.
    `HRBP_ASSERT_IMPLY(a_err_role, clk, rst_n,
        rsp_valid && rsp_word.status == hrbp_pkg::STATUS_ERROR,
        rsp_word.byte_role == hrbp_pkg::ROLE_DELIM)
    // Only restart words are pending and untaken, and they carry nothing.
    `HRBP_ASSERT_IMPLY(a_restart_blank, clk, rst_n,
        rsp_valid && !rsp_word.consumed && rsp_word.status == hrbp_pkg::STATUS_PENDING,
        rsp_word.out_byte == 8'd0 && rsp_word.byte_role == hrbp_pkg::ROLE_DELIM)
    // Status code three never appears.
    `HRBP_ASSERT_NEVER(a_status_code, clk, rst_n,
        rsp_valid && rsp_word.status == 2'd3)
    // Queue cannot be full while the back is free to drain it.
    `HRBP_ASSERT_NEVER(a_queue_drain, clk, rst_n,
        q_full && !rsp_valid && !q_pop)

endmodule

/* rtl/hrbp_front.sv */
// Front end: classifies each incoming byte and pushes it into the queue.
module hrbp_front (
    input  hrbp_pkg::req_t req_word,
    output hrbp_pkg::cls_t cls_word
);

    logic [7:0] b;
    logic       special;

    assign b = req_word.data_byte;

    always_comb
    begin
        case (b)
            "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/",
            "[", "]", "?", "=", "{", "}", " ", 8'h09: special = 1'b1;
            default: special = 1'b0;
        endcase
    end

    always_comb
    begin
        cls_word.cmd       = req_word.cmd;
        cls_word.data_byte = b;
        cls_word.lc_byte   = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        cls_word.ctl       = (b <= 8'd31) || (b == 8'd127);
        cls_word.tok       = (b > 8'd31) && (b < 8'd127) && !special;
        cls_word.dig       = (b >= "0") && (b <= "9");
        cls_word.blank     = (b == 8'h20) || (b == 8'h09) || (b == 8'h0b) || (b == 8'h0c);
        cls_word.hex_ok    = 1'b1;
        cls_word.hex_val   = 4'd0;
        if (b >= "0" && b <= "9")
        begin
            cls_word.hex_val = 4'(b - "0");
        end
        else if (b >= "a" && b <= "f")
        begin
            cls_word.hex_val = 4'(b - "a" + 8'd10);
        end
        else if (b >= "A" && b <= "F")
        begin
            cls_word.hex_val = 4'(b - "A" + 8'd10);
        end
        else
        begin
            cls_word.hex_ok = 1'b0;
        end
    end

endmodule

/* rtl/hrbp_queue.sv */
// Two-entry queue between the classifying front and the parsing back.
module hrbp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hrbp_pkg::cls_t push_word,
    output logic           full,
    input  logic           pop,
    output logic           nonempty,
    output hrbp_pkg::cls_t pop_word
);

    localparam int Depth = 2;
    localparam int AW    = $clog2(Depth);
    localparam int CW    = $clog2(Depth + 1);

    hrbp_pkg::cls_t entry_reg [Depth];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full     = (count_reg == CW'(Depth));
    assign nonempty = (count_reg != '0);
    assign pop_word = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

/* rtl/hrbp_back.sv */
// Back end: request parse state machine and registered result word.
module hrbp_back #(
    parameter int LENGTH_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  hrbp_pkg::limits_t limits,
    input  logic              q_nonempty,
    input  hrbp_pkg::cls_t    q_word,
    output logic              q_pop,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output hrbp_pkg::rsp_t    rsp_word
);

    localparam int LW = LENGTH_WIDTH;

    localparam logic [3:0] PH_RL_START   = 4'd0;
    localparam logic [3:0] PH_METHOD     = 4'd1;
    localparam logic [3:0] PH_URI        = 4'd2;
    localparam logic [3:0] PH_VERSION    = 4'd3;
    localparam logic [3:0] PH_HDR_START  = 4'd4;
    localparam logic [3:0] PH_HDR_NAME   = 4'd5;
    localparam logic [3:0] PH_HDR_VALUE  = 4'd6;
    localparam logic [3:0] PH_BODY       = 4'd7;
    localparam logic [3:0] PH_CK_SIZE    = 4'd8;
    localparam logic [3:0] PH_CK_EXT     = 4'd9;
    localparam logic [3:0] PH_CK_SIZE_LF = 4'd10;
    localparam logic [3:0] PH_CK_DATA    = 4'd11;
    localparam logic [3:0] PH_CK_DATA_LF = 4'd12;
    localparam logic [3:0] PH_TRAILER    = 4'd13;
    localparam logic [3:0] PH_DONE       = 4'd14;
    localparam logic [3:0] PH_ERROR      = 4'd15;

    localparam logic [1:0] LS_BLANKS = 2'd0;
    localparam logic [1:0] LS_DIGITS = 2'd1;
    localparam logic [1:0] LS_OVER   = 2'd2;

    localparam logic [1:0] MATCH_CL   = 2'd1;
    localparam logic [1:0] MATCH_TE   = 2'd2;
    localparam logic [1:0] MATCH_BOTH = 2'd3;

    logic [3:0]    ph_reg, ph_next;
    logic [16:0]   rlc_reg, rlc_next;
    logic [16:0]   hlc_reg, hlc_next;
    logic [8:0]    hls_reg, hls_next;
    logic [3:0]    vpos_reg, vpos_next;
    logic          vgood_reg, vgood_next;
    logic [4:0]    npos_reg, npos_next;
    logic [1:0]    match_reg, match_next;
    logic          lp_reg, lp_next;
    logic [LW-1:0] lv_reg, lv_next;
    logic [1:0]    lsp_reg, lsp_next;
    logic          linv_reg, linv_next;
    logic          ep_reg, ep_next;
    logic          cs_reg, cs_next;
    logic [2:0]    cmp_reg, cmp_next;
    logic [LW-1:0] csv_reg, csv_next;
    logic [LW-1:0] bc_reg, bc_next;

    logic           rsp_valid_reg;
    hrbp_pkg::rsp_t rsp_reg, rsp_next;

    logic [7:0]    b;
    logic [7:0]    ob;
    logic [2:0]    role;
    logic [1:0]    st;
    logic          cons;
    logic [4:0]    npos_cur;
    logic [1:0]    match_cur;
    logic [LW+3:0] prod;
    logic [63:0]   lv_wide;
    logic          ok;
    logic          cl_hit, te_hit;

    assign q_pop     = q_nonempty && (!rsp_valid_reg || rsp_ready);
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;
    assign b         = q_word.data_byte;
    assign prod      = ({4'd0, lv_reg} << 3) + ({4'd0, lv_reg} << 1)
                     + (LW + 4)'(b - "0");
    assign lv_wide   = 64'(lv_reg);

    always_comb
    begin
        ph_next    = ph_reg;
        rlc_next   = rlc_reg;
        hlc_next   = hlc_reg;
        hls_next   = hls_reg;
        vpos_next  = vpos_reg;
        vgood_next = vgood_reg;
        npos_next  = npos_reg;
        match_next = match_reg;
        lp_next    = lp_reg;
        lv_next    = lv_reg;
        lsp_next   = lsp_reg;
        linv_next  = linv_reg;
        ep_next    = ep_reg;
        cs_next    = cs_reg;
        cmp_next   = cmp_reg;
        csv_next   = csv_reg;
        bc_next    = bc_reg;
        ob         = b;
        role       = hrbp_pkg::ROLE_DELIM;
        st         = hrbp_pkg::STATUS_PENDING;
        cons       = 1'b1;
        ok         = 1'b0;
        cl_hit     = 1'b0;
        te_hit     = 1'b0;
        npos_cur   = (ph_reg == PH_HDR_START) ? 5'd0 : npos_reg;
        match_cur  = (ph_reg == PH_HDR_START) ? MATCH_BOTH : match_reg;

        if (q_word.cmd)
        begin
            // Restart: clear parse state, keep the limits.
            ph_next    = PH_RL_START;
            rlc_next   = '0;
            hlc_next   = '0;
            hls_next   = '0;
            vpos_next  = '0;
            vgood_next = 1'b1;
            npos_next  = '0;
            match_next = MATCH_BOTH;
            lp_next    = 1'b0;
            lv_next    = '0;
            lsp_next   = LS_BLANKS;
            linv_next  = 1'b0;
            ep_next    = 1'b0;
            cs_next    = 1'b0;
            cmp_next   = '0;
            csv_next   = '0;
            bc_next    = '0;
            cons       = 1'b0;
            ob         = '0;
        end
        else if (ph_reg == PH_ERROR)
        begin
            st   = hrbp_pkg::STATUS_ERROR;
            cons = 1'b0;
            ob   = '0;
        end
        else if (ph_reg == PH_DONE)
        begin
            st   = hrbp_pkg::STATUS_COMPLETE;
            cons = 1'b0;
            ob   = '0;
        end
        else
        begin
            if (ph_reg <= PH_VERSION)
            begin
                rlc_next = rlc_reg + 17'd1;
            end
            else if (ph_reg <= PH_HDR_VALUE)
            begin
                hlc_next = hlc_reg + 17'd1;
            end

            if (ph_reg <= PH_VERSION && rlc_next > {1'b0, limits.request_line_limit})
            begin
                ph_next = PH_ERROR;
            end
            else if (ph_reg >= PH_HDR_START && ph_reg <= PH_HDR_VALUE
                     && hlc_next > {1'b0, limits.header_line_limit})
            begin
                ph_next = PH_ERROR;
            end
            else
            begin
                case (ph_reg)
                    PH_RL_START:
                    begin
                        if (b == hrbp_pkg::CH_CR || b == hrbp_pkg::CH_LF)
                        begin
                            ph_next = PH_RL_START;
                        end
                        else if (!q_word.tok)
                        begin
                            ph_next = PH_ERROR;
                        end
                        else
                        begin
                            ph_next = PH_METHOD;
                            role    = hrbp_pkg::ROLE_METHOD;
                        end
                    end
                    PH_METHOD:
                    begin
                        if (b == hrbp_pkg::CH_SP)
                        begin
                            ph_next = PH_URI;
                        end
                        else if (!q_word.tok)
                        begin
                            ph_next = PH_ERROR;
                        end
                        else
                        begin
                            role = hrbp_pkg::ROLE_METHOD;
                        end
                    end
                    PH_URI:
                    begin
                        if (b == hrbp_pkg::CH_SP)
                        begin
                            ph_next = PH_VERSION;
                        end
                        else if (q_word.ctl)
                        begin
                            ph_next = PH_ERROR;
                        end
                        else
                        begin
                            role = hrbp_pkg::ROLE_URI;
                        end
                    end
                    PH_VERSION:
                    begin
                        if (b == hrbp_pkg::CH_CR)
                        begin
                            ph_next = PH_VERSION;
                        end
                        else if (b == hrbp_pkg::CH_LF)
                        begin
                            if (!vgood_reg || vpos_reg != 4'd8)
                            begin
                                ph_next = PH_ERROR;
                            end
                            else
                            begin
                                ph_next  = PH_HDR_START;
                                hlc_next = '0;
                            end
                        end
                        else if (q_word.ctl)
                        begin
                            ph_next = PH_ERROR;
                        end
                        else
                        begin
                            // Check HTTP/d.d one character at a time.
                            if (vpos_reg < 4'd5)
                            begin
                                ok = (http_char_at(vpos_reg) == b);
                            end
                            else if (vpos_reg == 4'd5 || vpos_reg == 4'd7)
                            begin
                                ok = q_word.dig;
                            end
                            else if (vpos_reg == 4'd6)
                            begin
                                ok = (b == hrbp_pkg::CH_DOT);
                            end
                            if (!ok)
                            begin
                                vgood_next = 1'b0;
                            end
                            if (vpos_reg < 4'd8)
                            begin
                                vpos_next = vpos_reg + 4'd1;
                            end
                            role = hrbp_pkg::ROLE_VERSION;
                        end
                    end
                    PH_HDR_START, PH_HDR_NAME:
                    begin
                        if (ph_reg == PH_HDR_START && b == hrbp_pkg::CH_CR)
                        begin
                            ph_next = PH_HDR_START;
                        end
                        else if (ph_reg == PH_HDR_START && b == hrbp_pkg::CH_LF)
                        begin
                            // End of headers: pick the body framing.
                            if (lp_reg && (linv_reg || lv_wide > 64'(limits.body_limit)))
                            begin
                                ph_next = PH_ERROR;
                            end
                            else if (ep_reg)
                            begin
                                if (!cs_reg)
                                begin
                                    ph_next = PH_ERROR;
                                end
                                else
                                begin
                                    csv_next = '0;
                                    ph_next  = PH_CK_SIZE;
                                end
                            end
                            else if (lp_reg && lv_reg != '0)
                            begin
                                bc_next = '0;
                                ph_next = PH_BODY;
                            end
                            else
                            begin
                                ph_next = PH_DONE;
                            end
                        end
                        else if (ph_reg == PH_HDR_NAME && b == hrbp_pkg::CH_COLON)
                        begin
                            cl_hit = match_reg[0] && (npos_reg == 5'd14);
                            te_hit = match_reg[1] && (npos_reg == 5'd17);
                            match_next = cl_hit ? MATCH_CL : (te_hit ? MATCH_TE : 2'd0);
                            if (cl_hit)
                            begin
                                lp_next   = 1'b1;
                                lv_next   = '0;
                                lsp_next  = LS_BLANKS;
                                linv_next = 1'b0;
                            end
                            if (te_hit)
                            begin
                                ep_next  = 1'b1;
                                cs_next  = 1'b0;
                                cmp_next = '0;
                            end
                            ph_next = PH_HDR_VALUE;
                        end
                        else if (!q_word.tok)
                        begin
                            ph_next = PH_ERROR;
                        end
                        else
                        begin
                            // Match the lowercased name against both candidates.
                            ob         = q_word.lc_byte;
                            match_next = match_cur;
                            if (npos_cur >= 5'd14 || hrbp_pkg::cl_char(npos_cur) != ob)
                            begin
                                match_next[0] = 1'b0;
                            end
                            if (npos_cur >= 5'd17 || hrbp_pkg::te_char(npos_cur) != ob)
                            begin
                                match_next[1] = 1'b0;
                            end
                            npos_next = (npos_cur < 5'd31) ? npos_cur + 5'd1 : npos_cur;
                            role      = hrbp_pkg::ROLE_NAME;
                            ph_next   = PH_HDR_NAME;
                        end
                    end
                    PH_HDR_VALUE:
                    begin
                        if (b == hrbp_pkg::CH_CR)
                        begin
                            ph_next = PH_HDR_VALUE;
                        end
                        else if (b == hrbp_pkg::CH_LF)
                        begin
                            if (match_reg == MATCH_CL && lsp_reg == LS_BLANKS)
                            begin
                                linv_next = 1'b1;
                            end
                            hls_next = hls_reg + 9'd1;
                            if (hls_next > {1'b0, limits.header_count_limit})
                            begin
                                ph_next = PH_ERROR;
                            end
                            else
                            begin
                                ph_next  = PH_HDR_START;
                                hlc_next = '0;
                            end
                        end
                        else
                        begin
                            if (match_reg == MATCH_CL)
                            begin
                                if (lsp_reg == LS_BLANKS && q_word.blank)
                                begin
                                    lsp_next = LS_BLANKS;
                                end
                                else if (lsp_reg == LS_BLANKS && !q_word.dig)
                                begin
                                    linv_next = 1'b1;
                                    lsp_next  = LS_OVER;
                                end
                                else if (lsp_reg == LS_BLANKS || lsp_reg == LS_DIGITS)
                                begin
                                    if (!q_word.dig)
                                    begin
                                        lsp_next = LS_OVER;
                                    end
                                    else if (prod[LW+3:LW] != 4'd0)
                                    begin
                                        linv_next = 1'b1;
                                        lsp_next  = LS_OVER;
                                    end
                                    else
                                    begin
                                        lv_next  = prod[LW-1:0];
                                        lsp_next = LS_DIGITS;
                                    end
                                end
                            end
                            else if (match_reg == MATCH_TE && !cs_reg)
                            begin
                                if (hrbp_pkg::ck_char(cmp_reg) == b)
                                begin
                                    if (cmp_reg == 3'd6)
                                    begin
                                        cs_next  = 1'b1;
                                        cmp_next = '0;
                                    end
                                    else
                                    begin
                                        cmp_next = cmp_reg + 3'd1;
                                    end
                                end
                                else
                                begin
                                    cmp_next = (b == hrbp_pkg::CH_C) ? 3'd1 : 3'd0;
                                end
                            end
                            role = hrbp_pkg::ROLE_VALUE;
                        end
                    end
                    PH_BODY:
                    begin
                        role    = hrbp_pkg::ROLE_BODY;
                        bc_next = bc_reg + LW'(1);
                        if (bc_next >= lv_reg)
                        begin
                            ph_next = PH_DONE;
                        end
                    end
                    PH_CK_SIZE:
                    begin
                        if (b == hrbp_pkg::CH_CR)
                        begin
                            ph_next = PH_CK_SIZE_LF;
                        end
                        else if (b == hrbp_pkg::CH_SEMI)
                        begin
                            ph_next = PH_CK_EXT;
                        end
                        else if (!q_word.hex_ok || csv_reg[LW-1:LW-4] != 4'd0)
                        begin
                            ph_next = PH_ERROR;
                        end
                        else
                        begin
                            csv_next = {csv_reg[LW-5:0], q_word.hex_val};
                        end
                    end
                    PH_CK_EXT:
                    begin
                        if (b == hrbp_pkg::CH_CR)
                        begin
                            ph_next = PH_CK_SIZE_LF;
                        end
                    end
                    PH_CK_SIZE_LF:
                    begin
                        if (b != hrbp_pkg::CH_LF)
                        begin
                            ph_next = PH_ERROR;
                        end
                        else if (csv_reg == '0)
                        begin
                            ph_next = PH_TRAILER;
                        end
                        else
                        begin
                            ph_next = PH_CK_DATA;
                            bc_next = '0;
                        end
                    end
                    PH_CK_DATA:
                    begin
                        role    = hrbp_pkg::ROLE_BODY;
                        bc_next = bc_reg + LW'(1);
                        if (bc_next >= csv_reg)
                        begin
                            ph_next = PH_CK_DATA_LF;
                        end
                    end
                    PH_CK_DATA_LF:
                    begin
                        if (b == hrbp_pkg::CH_LF)
                        begin
                            ph_next  = PH_CK_SIZE;
                            csv_next = '0;
                        end
                        else if (b != hrbp_pkg::CH_CR)
                        begin
                            ph_next = PH_ERROR;
                        end
                    end
                    PH_TRAILER:
                    begin
                        if (b == hrbp_pkg::CH_LF)
                        begin
                            ph_next = PH_DONE;
                        end
                    end
                    default:
                    begin
                        ph_next = PH_ERROR;
                    end
                endcase
            end

            if (ph_next == PH_ERROR)
            begin
                st   = hrbp_pkg::STATUS_ERROR;
                ob   = b;
                role = hrbp_pkg::ROLE_DELIM;
            end
            else if (ph_next == PH_DONE)
            begin
                st = hrbp_pkg::STATUS_COMPLETE;
            end
        end

        rsp_next.status         = st;
        rsp_next.consumed       = cons;
        rsp_next.out_byte       = ob;
        rsp_next.byte_role      = role;
        rsp_next.content_length = (lp_next && !linv_next) ? lv_next_wide(lv_next) : 32'd0;
        rsp_next.chunked        = ep_next && cs_next;
    end

    function automatic logic [7:0] http_char_at(input logic [3:0] pos);
        return hrbp_pkg::http_char(pos[2:0]);
    endfunction

    function automatic logic [31:0] lv_next_wide(input logic [LW-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[31:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg        <= PH_RL_START;
            rlc_reg       <= '0;
            hlc_reg       <= '0;
            hls_reg       <= '0;
            vpos_reg      <= '0;
            vgood_reg     <= 1'b1;
            npos_reg      <= '0;
            match_reg     <= MATCH_BOTH;
            lp_reg        <= 1'b0;
            lv_reg        <= '0;
            lsp_reg       <= LS_BLANKS;
            linv_reg      <= 1'b0;
            ep_reg        <= 1'b0;
            cs_reg        <= 1'b0;
            cmp_reg       <= '0;
            csv_reg       <= '0;
            bc_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                ph_reg    <= ph_next;
                rlc_reg   <= rlc_next;
                hlc_reg   <= hlc_next;
                hls_reg   <= hls_next;
                vpos_reg  <= vpos_next;
                vgood_reg <= vgood_next;
                npos_reg  <= npos_next;
                match_reg <= match_next;
                lp_reg    <= lp_next;
                lv_reg    <= lv_next;
                lsp_reg   <= lsp_next;
                linv_reg  <= linv_next;
                ep_reg    <= ep_next;
                cs_reg    <= cs_next;
                cmp_reg   <= cmp_next;
                csv_reg   <= csv_next;
                bc_reg    <= bc_next;
            end
            if (q_pop)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule
